### src/pwm_velocity_line_fit_unit_defines.svh
// Assertion macros used by the line fit unit controller.
`ifndef PWM_VELOCITY_LINE_FIT_UNIT_DEFINES_SVH
`define PWM_VELOCITY_LINE_FIT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PVLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PVLF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define PVLF_ASSERT(label, prop, msg)
`define PVLF_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### src/pvlf_pkg.sv
// Types, constants and helper functions of the line fit unit.
`timescale 1ns / 1ps
package pvlf_pkg;

    localparam int DIV_W = 49;
    localparam int DVS_W = 33;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PAIRS  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] factor;
        logic signed [31:0] offset;
        logic [63:0]        variance_sum;
        logic [1:0]         status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAIR,
        S_SDIV,
        S_SACC,
        S_MEAN,
        S_MDIV,
        S_OFF_MUL,
        S_OFF_FIN,
        S_WRD,
        S_WMUL,
        S_WERR,
        S_WSQ,
        S_WACC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_slope;
        logic div_mean;
        logic slope_acc;
        logic factor_cap;
        logic off_mul;
        logic off_fin;
        logic walk_rd;
        logic walk_mul;
        logic walk_err;
        logic walk_sq;
        logic walk_acc;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic pair;
        logic dx_zero;
        logic last;
        logic div_done;
        logic no_pairs;
        logic walk_last;
        logic out_free;
    } sts_t;

    // Signed division by 65536 with truncation toward zero.
    function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
        logic signed [65:0] q;
        q = v >>> 16;
        if (v[65] && (v[15:0] != 16'd0)) begin
            q = q + 66'sd1;
        end
        return q;
    endfunction

endpackage

### src/pwm_velocity_line_fit_unit.sv
// Top level of the line fit unit: configuration register and module wiring.
`timescale 1ns / 1ps
// Calibration line fit: loads signed Q16.16 (x, y) samples one word at a time, taking the next
// only once the last is handled; a word that forms a valid pair with a nonzero x step waits for
// the bit-serial divider that forms the pair slope (49 quotient bits, one per cycle). The word
// marked last_sample starts the fit: a mean division, the offset, then an error walk (read,
// multiply, error, square, accumulate) for each stored sample after the first through the
// single read port of the sample memory, and the load of the result register; all but that load
// are skipped when no valid pair was formed. New samples are taken while a result waits.
module pwm_velocity_line_fit_unit #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pvlf_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pvlf_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pvlf_pkg::*;

    logic [15:0] tol_reg;
    ctl_t        cmd;
    sts_t        sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 16'd1;
        end else if (psel && penable && pwrite) begin
            tol_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, tol_reg} : 32'd0;

    pvlf_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pvlf_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .tolerance (tol_reg),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### src/pvlf_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pvlf_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [pvlf_pkg::DIV_W-1:0] dividend,
    input  logic [pvlf_pkg::DVS_W-1:0] divisor,
    output logic [pvlf_pkg::DIV_W-1:0] quotient,
    output logic                      done
);
    import pvlf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    always_comb begin
        trial     = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### src/pvlf_datapath.sv
// Sample stores, slope accumulation, offset and error walk datapath.
`timescale 1ns / 1ps
module pvlf_datapath #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pvlf_pkg::ctl_t      cmd,
    output pvlf_pkg::sts_t      sts,
    input  logic [15:0]         tolerance,
    input  pvlf_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pvlf_pkg::out_word_t m_data
);
    import pvlf_pkg::*;

    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 33 + CW;

    logic signed [31:0] x_mem [MAX_SAMPLES];
    logic signed [31:0] y_mem [MAX_SAMPLES];

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       vp_reg;
    logic [CW-1:0]       wi_reg;
    logic signed [31:0]  prev_x_reg, prev_y_reg;
    logic signed [32:0]  dy_reg, dx_reg;
    logic                pair_reg, dx_zero_reg, last_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                sat_reg;
    logic signed [31:0]  factor_reg, offset_reg;
    logic signed [31:0]  xr_reg, yr_reg;
    logic signed [63:0]  prod_reg;
    logic [31:0]         me_reg;
    logic                big_reg, skip_reg;
    logic [63:0]         sq_reg, var_reg;
    out_word_t           out_reg;
    logic                m_valid_reg;

    logic signed [32:0]  dy_in, dx_in;
    logic [32:0]         dy_mag_in, py_mag, dy_mag, dx_mag, xr_mag;
    logic                room, pair_in;
    logic [SUM_W-1:0]    sum_mag;
    logic [DIV_W-1:0]    div_dividend, quotient;
    logic [DVS_W-1:0]    div_divisor;
    logic                div_done;
    logic                slope_neg, slope_sat;
    logic signed [31:0]  slope_val;
    logic [31:0]         mean_mag;
    logic signed [65:0]  off_v, off_q, err_v, err_q;
    logic [65:0]         err_mag;
    logic [64:0]         acc_sum;

    always_comb begin
        room      = count_reg < CW'(MAX_SAMPLES);
        dy_in     = {s_data.y_value[31], s_data.y_value} - {prev_y_reg[31], prev_y_reg};
        dx_in     = {s_data.x_value[31], s_data.x_value} - {prev_x_reg[31], prev_x_reg};
        dy_mag_in = dy_in[32] ? 33'(-dy_in) : dy_in;
        py_mag    = prev_y_reg[31] ? 33'(-{1'b1, prev_y_reg}) : {1'b0, prev_y_reg};
        pair_in   = (count_reg != '0) && (dy_mag_in > {17'd0, tolerance})
                    && (py_mag > {17'd0, tolerance});
        dy_mag    = dy_reg[32] ? 33'(-dy_reg) : dy_reg;
        dx_mag    = dx_reg[32] ? 33'(-dx_reg) : dx_reg;
        sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
        xr_mag    = xr_reg[31] ? 33'(-{1'b1, xr_reg}) : {1'b0, xr_reg};
    end

    always_comb begin
        if (cmd.div_mean) begin
            div_dividend = DIV_W'(sum_mag);
            div_divisor  = DVS_W'(vp_reg);
        end else begin
            div_dividend = {dy_mag, 16'd0};
            div_divisor  = dx_mag;
        end
    end

    pvlf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_slope | cmd.div_mean),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb begin
        slope_neg = dy_reg[32] ^ dx_reg[32];
        slope_sat = 1'b0;
        slope_val = 32'(quotient);
        if (dx_zero_reg) begin
            slope_sat = 1'b1;
            slope_val = dy_reg[32] ? Q_MIN : Q_MAX;
        end else if (slope_neg) begin
            if (quotient > DIV_W'(33'h0_8000_0000)) begin
                slope_sat = 1'b1;
                slope_val = Q_MIN;
            end else begin
                slope_val = 32'(-quotient);
            end
        end else if (quotient > DIV_W'(32'h7FFF_FFFF)) begin
            slope_sat = 1'b1;
            slope_val = Q_MAX;
        end
        mean_mag = quotient[31:0];
        off_v    = {{18{prev_y_reg[31]}}, prev_y_reg, 16'd0} - {{2{prod_reg[63]}}, prod_reg};
        off_q    = trunc16(off_v);
        err_v    = {{2{prod_reg[63]}}, prod_reg} + {{18{offset_reg[31]}}, offset_reg, 16'd0}
                   - {{18{yr_reg[31]}}, yr_reg, 16'd0};
        err_q    = trunc16(err_v);
        err_mag  = err_q[65] ? 66'(-err_q) : err_q;
        acc_sum  = {1'b0, var_reg} + {1'b0, sq_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && room) begin
            x_mem[count_reg[AW-1:0]] <= s_data.x_value;
            y_mem[count_reg[AW-1:0]] <= s_data.y_value;
        end
        if (cmd.walk_rd) begin
            xr_reg <= x_mem[wi_reg[AW-1:0]];
            yr_reg <= y_mem[wi_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            vp_reg      <= '0;
            sum_reg     <= '0;
            sat_reg     <= 1'b0;
            var_reg     <= '0;
            m_valid_reg <= 1'b0;
            pair_reg    <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                last_reg <= s_data.last_sample;
                pair_reg <= room && pair_in;
                if (room) begin
                    count_reg  <= count_reg + 1'b1;
                    prev_x_reg <= s_data.x_value;
                    prev_y_reg <= s_data.y_value;
                end
                dy_reg      <= dy_in;
                dx_reg      <= dx_in;
                dx_zero_reg <= (dx_in == '0);
            end
            if (cmd.slope_acc) begin
                sum_reg <= sum_reg + {{(SUM_W-32){slope_val[31]}}, slope_val};
                vp_reg  <= vp_reg + 1'b1;
                if (slope_sat) begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.factor_cap) begin
                factor_reg <= sum_reg[SUM_W-1] ? 32'(-mean_mag) : mean_mag;
            end
            if (cmd.off_mul) begin
                prod_reg <= prev_x_reg * factor_reg;
            end
            if (cmd.off_fin) begin
                wi_reg <= CW'(1);
                if (off_q > 66'sd2147483647) begin
                    offset_reg <= Q_MAX;
                    sat_reg    <= 1'b1;
                end else if (off_q < -66'sd2147483648) begin
                    offset_reg <= Q_MIN;
                    sat_reg    <= 1'b1;
                end else begin
                    offset_reg <= off_q[31:0];
                end
            end
            if (cmd.walk_mul) begin
                prod_reg <= xr_reg * factor_reg;
                skip_reg <= xr_mag <= {17'd0, tolerance};
            end
            if (cmd.walk_err) begin
                big_reg <= err_mag > 66'h0_FFFF_FFFF;
                me_reg  <= err_mag[31:0];
            end
            if (cmd.walk_sq) begin
                sq_reg <= big_reg ? '1 : {32'd0, me_reg} * {32'd0, me_reg};
            end
            if (cmd.walk_acc) begin
                wi_reg <= wi_reg + 1'b1;
                if (!skip_reg) begin
                    if (big_reg || acc_sum[64]) begin
                        sat_reg <= 1'b1;
                    end
                    var_reg <= acc_sum[64] ? '1 : acc_sum[63:0];
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                if (vp_reg == '0) begin
                    out_reg <= '{factor: '0, offset: '0, variance_sum: '0,
                                 status: ST_NO_PAIRS};
                end else begin
                    out_reg <= '{factor: factor_reg, offset: offset_reg,
                                 variance_sum: var_reg,
                                 status: sat_reg ? ST_SATURATED : ST_OK};
                end
                count_reg <= '0;
                vp_reg    <= '0;
                sum_reg   <= '0;
                sat_reg   <= 1'b0;
                var_reg   <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.pair      = pair_reg;
        sts.dx_zero   = dx_zero_reg;
        sts.last      = last_reg;
        sts.div_done  = div_done;
        sts.no_pairs  = (vp_reg == '0);
        sts.walk_last = (wi_reg == count_reg - 1'b1);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### src/pvlf_controller.sv
// Sequencer that steps the datapath through loading, division and the error walk.
`timescale 1ns / 1ps
`include "pwm_velocity_line_fit_unit_defines.svh"
module pvlf_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pvlf_pkg::sts_t sts,
    output pvlf_pkg::ctl_t cmd
);
    import pvlf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_PAIR;
            end
            S_PAIR: begin
                if (!sts.pair) state_next = sts.last ? S_MEAN : S_IDLE;
                else if (sts.dx_zero) state_next = S_SACC;
                else state_next = S_SDIV;
            end
            S_SDIV: begin
                if (sts.div_done) state_next = S_SACC;
            end
            S_SACC: begin
                state_next = sts.last ? S_MEAN : S_IDLE;
            end
            S_MEAN: begin
                state_next = sts.no_pairs ? S_FINISH : S_MDIV;
            end
            S_MDIV: begin
                if (sts.div_done) state_next = S_OFF_MUL;
            end
            S_OFF_MUL: state_next = S_OFF_FIN;
            S_OFF_FIN: state_next = S_WRD;
            S_WRD:     state_next = S_WMUL;
            S_WMUL:    state_next = S_WERR;
            S_WERR:    state_next = S_WSQ;
            S_WSQ:     state_next = S_WACC;
            S_WACC: begin
                state_next = sts.walk_last ? S_FINISH : S_WRD;
            end
            S_FINISH: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_PAIR: begin
                cmd.div_slope = sts.pair && !sts.dx_zero;
            end
            S_SDIV: ;
            S_SACC: cmd.slope_acc = 1'b1;
            S_MEAN: cmd.div_mean = !sts.no_pairs;
            S_MDIV: cmd.factor_cap = sts.div_done;
            S_OFF_MUL: cmd.off_mul = 1'b1;
            S_OFF_FIN: cmd.off_fin = 1'b1;
            S_WRD: cmd.walk_rd = 1'b1;
            S_WMUL: cmd.walk_mul = 1'b1;
            S_WERR: cmd.walk_err = 1'b1;
            S_WSQ: cmd.walk_sq = 1'b1;
            S_WACC: cmd.walk_acc = 1'b1;
            S_FINISH: cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

    `PVLF_ASSERT(a_done_in_div, sts.div_done |-> (state_reg == S_SDIV || state_reg == S_MDIV), "divider finished outside a division state")
    `PVLF_ASSERT(a_pair_starts_div, (state_reg == S_PAIR && sts.pair && !sts.dx_zero) |=> (state_reg == S_SDIV), "valid pair did not start a division")
    `PVLF_ASSERT_NEVER(a_out_overwrite, cmd.out_load && !sts.out_free, "result loaded over an untaken word")

endmodule
